FILE: hdl/mmlr_pkg.sv
// Shared types and constants for the mono mix-down linear resampler.
// Used by every module under hdl/; depends on nothing.
package mmlr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;

  localparam int GAIN_W     = FRAC_BITS + 1;
  localparam int STEP_W     = FRAC_BITS + 5;
  localparam int PHASE_W    = FRAC_BITS + 5;
  localparam int ACC_W      = SAMPLE_BITS + FRAC_BITS + 4;
  localparam int CFG_DATA_W = STEP_W;

  // shared serial multiplier: signed A by unsigned B
  localparam int MUL_AW    = SAMPLE_BITS + 1;
  localparam int MUL_BW    = FRAC_BITS + 1;
  localparam int PROD_W    = MUL_AW + 1 + MUL_BW;
  localparam int MUL_CNT_W = $clog2(MUL_BW);

  localparam logic [PHASE_W-1:0] ONE_Q    = PHASE_W'(64'd1 << FRAC_BITS);
  localparam logic [PHASE_W-1:0] TWO_Q    = PHASE_W'(64'd2 << FRAC_BITS);
  localparam logic [STEP_W-1:0]  STEP_MIN = STEP_W'(64'd1 << (FRAC_BITS - 4));
  localparam logic [STEP_W-1:0]  STEP_MAX = STEP_W'(64'd1 << (FRAC_BITS + 4));
  localparam logic [GAIN_W-1:0]  GAIN_ONE = GAIN_W'(64'd1 << FRAC_BITS);
  localparam logic [STEP_W-1:0]  STEP_ONE = STEP_W'(64'd1 << FRAC_BITS);
  localparam logic [63:0]        HALF_Q   = 64'd1 << (FRAC_BITS - 1);

  typedef enum logic [0:0] {
    CFG_MIX_GAIN      = 1'b0,
    CFG_RESAMPLE_STEP = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_ROUND,
    ST_MAIN_CHECK,
    ST_INTERP,
    ST_EMIT,
    ST_TAIL_CHECK,
    ST_TAIL_EMIT
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] mix_gain;
    logic [STEP_W-1:0] resample_step;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          last_in_frame;
    logic                          last_in_file;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          end_of_run;
    logic                          end_of_stream;
  } out_item_t;

endpackage

FILE: hdl/mmlr_serial_mul.sv
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
// Signed MUL_AW-bit operand times unsigned MUL_BW-bit operand; uses mmlr_pkg.
module mmlr_serial_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mmlr_pkg::MUL_AW-1:0] a,
  input  logic [mmlr_pkg::MUL_BW-1:0] b,
  output logic                        busy,
  output logic [mmlr_pkg::PROD_W-1:0] product
);
  import mmlr_pkg::*;

  logic                 busy_r;
  logic [MUL_AW-1:0]    a_r;
  logic [MUL_AW:0]      hi_r;
  logic [MUL_BW-1:0]    lo_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_AW:0]      sum;
  logic                 last_step;

  assign sum       = hi_r + (lo_r[0] ? {a_r[MUL_AW-1], a_r} : '0);
  assign last_step = (cnt_r == MUL_CNT_W'(MUL_BW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && last_step) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      hi_r  <= '0;
      lo_r  <= b;
      cnt_r <= '0;
    end else if (busy_r) begin
      hi_r  <= {sum[MUL_AW], sum[MUL_AW:1]};
      lo_r  <= {sum[0], lo_r[MUL_BW-1:1]};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy    = busy_r;
  assign product = {hi_r, lo_r};

endmodule

FILE: hdl/mmlr_core.sv
// Sequencer and datapath: channel mix accumulate, mono rounding, phase stepping
// and interpolation. Uses mmlr_pkg and mmlr_serial_mul.
module mmlr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  mmlr_pkg::cfg_regs_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmlr_pkg::in_item_t  in_item,
  output logic                res_valid,
  input  logic                res_ready,
  output mmlr_pkg::out_item_t res
);
  import mmlr_pkg::*;

  localparam int S = SAMPLE_BITS;
  localparam int F = FRAC_BITS;

  state_t             state_r, state_nxt;
  logic [ACC_W-1:0]   mix_sum_r, mix_sum_nxt;
  logic [S-1:0]       prev_r, prev_nxt;
  logic [S-1:0]       mono_r, mono_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               eof_r, eof_nxt;
  logic               eofr_r, eofr_nxt;

  logic              mul_start, mul_busy;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  logic [STEP_W-1:0]  step_c;
  logic [MUL_AW-1:0]  diff;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [ACC_W:0]     rnd;
  logic [ACC_W-F:0]   mono_sh;
  logic [ACC_W-F-S+1:0] mono_top;
  logic [S-1:0]       mono_sat;
  logic [PROD_W-1:0]  q;
  logic [PROD_W-F-1:0] interp;
  logic [PHASE_W-1:0] ph_add;
  logic               main_last;
  logic               accept;

  mmlr_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mix_sum_r   <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      eof_r       <= 1'b0;
      eofr_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mix_sum_r   <= mix_sum_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      phase_r     <= phase_nxt;
      eof_r       <= eof_nxt;
      eofr_r      <= eofr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mono_r <= mono_nxt;
  end

  always_comb begin
    // datapath
    if (cfg.resample_step < STEP_MIN) begin
      step_c = STEP_MIN;
    end else if (cfg.resample_step > STEP_MAX) begin
      step_c = STEP_MAX;
    end else begin
      step_c = cfg.resample_step;
    end

    diff    = {mono_r[S-1], mono_r} - {prev_r[S-1], prev_r};
    acc_sum = {mix_sum_r[ACC_W-1], mix_sum_r}
              + {{(ACC_W + 1 - PROD_W){mul_p[PROD_W-1]}}, mul_p};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end

    rnd      = {mix_sum_r[ACC_W-1], mix_sum_r} + (ACC_W+1)'(HALF_Q);
    mono_sh  = rnd[ACC_W:F];
    mono_top = mono_sh[ACC_W-F:S-1];
    if ((&mono_top) || !(|mono_top)) begin
      mono_sat = mono_sh[S-1:0];
    end else begin
      mono_sat = mono_sh[ACC_W-F] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end

    q         = mul_p + PROD_W'(HALF_Q);
    interp    = {{(PROD_W-F-S){prev_r[S-1]}}, prev_r} + q[PROD_W-1:F];
    ph_add    = phase_r + PHASE_W'(step_c);
    main_last = eof_r ? (ph_add >= TWO_Q) : (ph_add >= ONE_Q);

    // control
    state_nxt     = state_r;
    mix_sum_nxt   = mix_sum_r;
    prev_nxt      = prev_r;
    mono_nxt      = mono_r;
    have_prev_nxt = have_prev_r;
    phase_nxt     = phase_r;
    eof_nxt       = eof_r;
    eofr_nxt      = eofr_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    res           = '0;
    mul_start     = 1'b0;
    mul_a         = diff;
    mul_b         = {1'b0, phase_r[F-1:0]};
    accept        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        mul_a    = {in_item.in_sample[S-1], in_item.in_sample};
        mul_b    = cfg.mix_gain;
        if (accept) begin
          mul_start = 1'b1;
          eof_nxt   = in_item.last_in_file;
          eofr_nxt  = in_item.last_in_frame | in_item.last_in_file;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (!mul_busy) begin
          mix_sum_nxt = acc_sat;
          state_nxt   = eofr_r ? ST_ROUND : ST_IDLE;
        end
      end
      ST_ROUND: begin
        mix_sum_nxt = '0;
        if (!have_prev_r) begin
          prev_nxt      = mono_sat;
          have_prev_nxt = 1'b1;
          phase_nxt     = '0;
          state_nxt     = eof_r ? ST_TAIL_CHECK : ST_IDLE;
        end else begin
          mono_nxt  = mono_sat;
          state_nxt = ST_MAIN_CHECK;
        end
      end
      ST_MAIN_CHECK: begin
        if (phase_r < ONE_Q) begin
          mul_start = 1'b1;
          state_nxt = ST_INTERP;
        end else begin
          phase_nxt = phase_r - ONE_Q;
          prev_nxt  = mono_r;
          state_nxt = eof_r ? ST_TAIL_CHECK : ST_IDLE;
        end
      end
      ST_INTERP: begin
        if (!mul_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid         = 1'b1;
        res.out_sample    = interp[S-1:0];
        res.end_of_run    = main_last;
        res.end_of_stream = eof_r & main_last;
        if (res_ready) begin
          phase_nxt = ph_add;
          state_nxt = ST_MAIN_CHECK;
        end
      end
      ST_TAIL_CHECK: begin
        if (phase_r < ONE_Q) begin
          state_nxt = ST_TAIL_EMIT;
        end else begin
          prev_nxt      = '0;
          have_prev_nxt = 1'b0;
          phase_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_TAIL_EMIT: begin
        res_valid         = 1'b1;
        res.out_sample    = prev_r;
        res.end_of_run    = (ph_add >= ONE_Q);
        res.end_of_stream = (ph_add >= ONE_Q);
        if (res_ready) begin
          phase_nxt = ph_add;
          state_nxt = ST_TAIL_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/mono_mix_linear_resampler_top.sv
// Top level of the mono mix-down linear resampler: configuration registers,
// output register and the core. Uses mmlr_pkg and mmlr_core.
//
// Input channel (in_valid/in_ready/in_item): one channel sample per item,
// interleaved; last_in_frame closes a frame, last_in_file closes the stream.
// Output channel (out_valid/out_ready/out_item): resampled mono samples;
// end_of_run marks the last result of an input frame, end_of_stream the last
// result of the stream.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while the block is idle.
// Processing: one item is worked on at a time. Each item runs the shared
// bit-serial multiplier once for the mix. A frame end adds a rounding
// step; on a stream's first frame that step only stores the mono sample, and
// otherwise each output takes a phase check and one multiplier pass to
// interpolate. At stream end the last mono sample is repeated as a tail.
// Each result is registered in the output register before out_item.
// Reset (synchronous, rst_n low) sets gain and step to 1.0 and clears all
// stream state. A result waits in the output register; when the receiver
// stalls, the core holds its next result and stops there.
module mono_mix_linear_resampler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mmlr_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mmlr_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  mmlr_pkg::cfg_idx_t              cfg_index,
  input  logic [mmlr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mmlr_pkg::*;

  cfg_regs_t cfg_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      res_valid, res_ready;
  out_item_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mix_gain      <= GAIN_ONE;
      cfg_r.resample_step <= STEP_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIX_GAIN:      cfg_r.mix_gain      <= cfg_data[GAIN_W-1:0];
        CFG_RESAMPLE_STEP: cfg_r.resample_step <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mmlr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
